// File: rtl/timed_note_voice_allocator_core_defines.svh
// Assertion macros for the timed note voice allocator.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
`ifndef TIMED_NOTE_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define TIMED_NOTE_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clk edge, masked while rst is high.
`define TNVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clk edge, reset included.
`define TNVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TNVA_ASSERT(lbl, prop, msg)
`define TNVA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/tnva_pkg.sv
// Shared types and constants of the timed note voice allocator.
// No dependencies; imported by tnva_cell, the top level and the test files.
`default_nettype none

package tnva_pkg;

  localparam int VOICES = 8;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CHAN_W  = 5;
  localparam int VOICE_W = 5;
  localparam int TIME_W  = 32;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_CHECK = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_PER_NOTE_CHANNEL = 1'b0,
    REG_DEFAULT_CHANNEL  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
    logic [TIME_W-1:0] hold_ms;
    logic [CHAN_W-1:0] note_channel;
  } item_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  out_note;
    logic [VEL_W-1:0]   out_velocity;
    logic [CHAN_W-1:0]  out_channel;
    logic [VOICE_W-1:0] out_voice;
    logic               last;
  } result_t;

  // Item as held during a scan: expiry already summed.
  typedef struct packed {
    opcode_t           opcode;
    logic [TIME_W-1:0] now_ms;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] expiry;
    logic [CHAN_W-1:0] channel;
  } job_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic load;  // seed the token into the first cell
    logic step;  // advance the token one cell
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tnva_cell.sv
// One voice slot of the allocator chain: slot storage, hit test and token stage.
// Depends on tnva_pkg.
`default_nettype none

module tnva_cell import tnva_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  job_t              job,
  input  logic [VIDX_W-1:0] index,
  input  logic              token_in,
  output logic              token_out,
  output logic              active,
  input  logic              below_in,
  output logic              below_out,
  output logic              emit,
  output result_t           res
);

  logic              token;
  logic [NOTE_W-1:0] slot_note;
  logic [VEL_W-1:0]  slot_velocity;
  logic [TIME_W-1:0] slot_expiry;
  logic [CHAN_W-1:0] slot_channel;

  logic    busy;
  logic    is_start;
  logic    hit;
  result_t word;

  assign busy     = (slot_velocity != '0);
  assign is_start = (job.opcode == OP_START);
  assign hit      = is_start ? !busy : (busy && (slot_expiry <= job.now_ms));

  assign emit      = token & ctl.step & hit;
  // A start stops at the first free slot; a check walks the whole row.
  assign token_out = token & !(is_start & hit);
  assign active    = token;
  assign below_out = hit | below_in;

  always_comb begin
    word.out_note     = is_start ? job.note : slot_note;
    word.out_velocity = is_start ? job.velocity : '0;
    word.out_channel  = is_start ? job.channel : slot_channel;
    word.out_voice    = VOICE_W'(index);
    word.last         = is_start ? 1'b1 : !below_in;
    res               = emit ? word : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token         <= 1'b0;
      slot_velocity <= '0;
    end else begin
      if (ctl.load | ctl.step) begin
        token <= token_in;
      end
      if (emit) begin
        slot_velocity <= is_start ? job.velocity : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && is_start) begin
      slot_note    <= job.note;
      slot_expiry  <= job.expiry;
      slot_channel <= job.channel;
    end
  end

endmodule

`default_nettype wire

// File: rtl/timed_note_voice_allocator_core.sv
// Timed note voice allocator: a row of VOICES slot cells scanned by a walking token.
// Each result word is registered in the output register when the cell holding the token
// fires; the token advances only while that register is empty or being drained.
// A new item is taken only once the last scan has ended; the token advance through the
// cell row sets this; a check walks all of it, a start stops at the first free slot.
// Reset (rst, synchronous): all slots free, per_note_channel 0, default_channel 1.
`default_nettype none
`include "timed_note_voice_allocator_core_defines.svh"

module timed_note_voice_allocator_core import tnva_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  // result channel
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CHAN_W-1:0] cfg_data
);

  // Configuration registers.
  logic              per_note_channel;
  logic [CHAN_W-1:0] default_channel;

  // Item held for the duration of one scan.
  job_t job;

  // Chain wiring between neighboring cells.
  logic [VOICES-1:0] token_in_vec;
  logic [VOICES-1:0] token_out_vec;
  logic [VOICES-1:0] token_vec;
  logic [VOICES-1:0] below_in_vec;
  logic [VOICES-1:0] below_out_vec;
  logic [VOICES-1:0] emit_vec;
  result_t           res_vec [VOICES];

  cell_ctl_t ctl;
  logic      busy;
  logic      out_free;
  logic      load;
  result_t   merged;
  result_t   picked;
  logic      start_claim;

  // Scan in progress while any cell holds the token.
  assign busy       = |token_vec;
  assign item_stall = busy;
  assign load       = item_valid & !item_stall;
  assign cfg_ready  = 1'b1;

  // Output register can take a word when empty or being drained.
  assign out_free = !result_valid | !result_stall;
  assign ctl.load = load;
  assign ctl.step = busy & out_free;

  genvar gi;
  generate
    for (gi = 0; gi < VOICES; gi++) begin : g_cell
      // Feed the token from the left neighbor; seed cell 0 on acceptance.
      if (gi == 0) begin : g_head
        assign token_in_vec[gi] = load;
      end else begin : g_body
        assign token_in_vec[gi] = token_out_vec[gi-1];
      end
      // Hits further down the row decide the last flag of a check.
      if (gi == VOICES - 1) begin : g_tail
        assign below_in_vec[gi] = 1'b0;
      end else begin : g_inner
        assign below_in_vec[gi] = below_out_vec[gi+1];
      end

      tnva_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .job       (job),
        .index     (VIDX_W'(gi)),
        .token_in  (token_in_vec[gi]),
        .token_out (token_out_vec[gi]),
        .active    (token_vec[gi]),
        .below_in  (below_in_vec[gi]),
        .below_out (below_out_vec[gi]),
        .emit      (emit_vec[gi]),
        .res       (res_vec[gi])
      );
    end
  endgenerate

  // Only the token holder drives a nonzero word; merge them by OR.
  always_comb begin
    merged = '0;
    for (int i = 0; i < VOICES; i++) begin
      merged = merged | res_vec[i];
    end
    picked = merged;
    // Apply the channel mode that holds now, also for note-offs.
    picked.out_channel = per_note_channel ? merged.out_channel : default_channel;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      per_note_channel <= 1'b0;
      default_channel  <= CHAN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_PER_NOTE_CHANNEL: per_note_channel <= cfg_data[0];
        REG_DEFAULT_CHANNEL:  default_channel  <= cfg_data;
        default:              per_note_channel <= per_note_channel;
      endcase
    end
  end

  // Capture the item and precompute the expiry, modulo 2^32.
  always_ff @(posedge clk) begin
    if (load) begin
      job.opcode   <= opcode_t'(item.opcode);
      job.now_ms   <= item.now_ms;
      job.note     <= item.note_number;
      job.velocity <= item.note_velocity;
      job.expiry   <= item.now_ms + item.hold_ms;
      job.channel  <= item.note_channel;
    end
  end

  // Output register: load a word when a cell fires, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= ctl.step & (|emit_vec);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && (|emit_vec)) begin
      result <= picked;
    end
  end

  // A start claims its slot in this cycle.
  assign start_claim = ctl.step & (|emit_vec) & (job.opcode == OP_START);

  // The token lives in at most one cell.
  `TNVA_ASSERT(a_token_single, $onehot0(token_vec), "token held by more than one cell")
  // Only the token holder may fire.
  `TNVA_ASSERT(a_emit_single, $onehot0(emit_vec), "more than one cell fired")
  // An accepted item seeds the token at the head of the row.
  `TNVA_ASSERT(a_seed, load |=> token_vec[0], "token not seeded after accept")
  // A start that found a slot ends the scan.
  `TNVA_ASSERT(a_start_ends, start_claim |=> !busy, "start scan kept running after claim")
  // A fired word reaches the output register.
  `TNVA_ASSERT(a_word_loaded, (ctl.step && (|emit_vec)) |=> result_valid, "fired word not presented")

endmodule

`default_nettype wire

// File: test/tnva_message_checker.sv
// Checker for the timed note voice allocator: watches the item, result and register
// write channels, keeps its own copy of the voice table and compares every result word.
// Depends on tnva_pkg for the word types, the opcode and the register index names.

module tnva_message_checker import tnva_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  item_t             item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CHAN_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);

  logic [NOTE_W-1:0] voice_note   [VOICES];
  logic [VEL_W-1:0]  voice_vel    [VOICES];
  logic [TIME_W-1:0] voice_expiry [VOICES];
  logic [CHAN_W-1:0] voice_chan   [VOICES];
  logic              use_own_chan;
  logic [CHAN_W-1:0] global_chan;

  // note-on / note-off words still to come, oldest first
  result_t due_messages[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic logic [CHAN_W-1:0] send_chan(input logic [CHAN_W-1:0] own);
    return use_own_chan ? own : global_chan;
  endfunction

  function automatic result_t make_msg(input logic [NOTE_W-1:0] note,
                                       input logic [VEL_W-1:0] vel,
                                       input logic [CHAN_W-1:0] chan, input int voice);
    result_t m;
    m.out_note     = note;
    m.out_velocity = vel;
    m.out_channel  = chan;
    m.out_voice    = VOICE_W'(voice);
    m.last         = 1'b0;
    return m;
  endfunction

  // Start takes the lowest free voice; check releases every due voice in order.
  task automatic allocate_or_release(input item_t w);
    result_t msgs [VOICES];
    int      n;
    bit      placed;
    n      = 0;
    placed = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (w.opcode == OP_START) begin
        if (!placed && voice_vel[v] == '0) begin
          voice_note[v]   = w.note_number;
          voice_vel[v]    = w.note_velocity;
          voice_expiry[v] = w.now_ms + w.hold_ms;
          voice_chan[v]   = w.note_channel;
          msgs[0] = make_msg(w.note_number, w.note_velocity, send_chan(w.note_channel), v);
          n       = 1;
          placed  = 1'b1;
        end
      end else if (voice_vel[v] != '0 && voice_expiry[v] <= w.now_ms) begin
        msgs[n]      = make_msg(voice_note[v], '0, send_chan(voice_chan[v]), v);
        voice_vel[v] = '0;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      msgs[k].last = (k == n - 1);
      due_messages.push_back(msgs[k]);
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_messages.size() == 0) begin
      report_mismatch($sformatf("unexpected word note=%0d vel=%0d voice=%0d",
                                got.out_note, got.out_velocity, got.out_voice));
    end else begin
      want = due_messages.pop_front();
      if (got.out_note !== want.out_note)
        report_mismatch($sformatf("out_note %0d, want %0d", got.out_note, want.out_note));
      if (got.out_velocity !== want.out_velocity)
        report_mismatch($sformatf("out_velocity %0d, want %0d",
                                  got.out_velocity, want.out_velocity));
      if (got.out_channel !== want.out_channel)
        report_mismatch($sformatf("out_channel %0d, want %0d",
                                  got.out_channel, want.out_channel));
      if (got.out_voice !== want.out_voice)
        report_mismatch($sformatf("out_voice %0d, want %0d", got.out_voice, want.out_voice));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) voice_vel[v] = '0;
      use_own_chan = 1'b0;
      global_chan  = CHAN_W'(1);
      due_messages.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_PER_NOTE_CHANNEL: use_own_chan = cfg_data[0];
          REG_DEFAULT_CHANNEL:  global_chan  = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) allocate_or_release(item);
      if (result_valid && !result_stall) check_result(result);
    end
    pending = due_messages.size();
  end

endmodule

// File: test/tb_timed_note_voice_allocator_core.sv
// Testbench top for timed_note_voice_allocator_core: clock, reset, stimulus and verdict.
// Depends on tnva_pkg, the block itself and tnva_message_checker, which does the checking.

module tb_timed_note_voice_allocator_core;
  import tnva_pkg::*;

  // Cycles with no word moving on any channel before the run is declared hung.
  // Covers the long receiver hold-off, the settle pauses and heavy random stalls.
  localparam int WATCHDOG_LIMIT  = 3000;
  // Quiet cycles after the last expected word: a full scan plus margin.
  localparam int SETTLE_CYCLES   = 2 * VOICES + 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 42;

  logic              clk;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  item_t             item         = '0;
  logic              item_stall;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index    = REG_PER_NOTE_CHANNEL;
  logic [CHAN_W-1:0] cfg_data     = '0;

  int                fail_count;
  int                pending;

  // Idle controls; the receiver's percentage is read in its own process.
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  logic              hold_kick      = 1'b0;
  logic              hold_seen      = 1'b0;
  int                hold_left      = 0;
  int                idle_cycles    = 0;
  // Running millisecond clock of the well-formed traffic.
  logic [TIME_W-1:0] clock_ms       = '0;

  timed_note_voice_allocator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tnva_message_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off whenever the stimulus flips hold_kick.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      hold_seen    <= hold_kick;
      hold_left    <= HOLD_OFF_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: restart on any handshake, give up after a long silence.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic item_t word_of(input opcode_t op, input logic [TIME_W-1:0] now,
                                    input logic [NOTE_W-1:0] note,
                                    input logic [VEL_W-1:0] vel,
                                    input logic [TIME_W-1:0] hold,
                                    input logic [CHAN_W-1:0] chan);
    item_t w;
    w.opcode        = op;
    w.now_ms        = now;
    w.note_number   = note;
    w.note_velocity = vel;
    w.hold_ms       = hold;
    w.note_channel  = chan;
    return w;
  endfunction

  // Mostly well-formed traffic on an advancing clock: starts with short holds so the
  // table fills and drains, checks at the current time, and a little pure noise.
  function automatic item_t random_word();
    item_t w;
    int    pick;
    pick     = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 40);
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    w = word_of(OP_CHECK, clock_ms, NOTE_W'($urandom_range(0, 127)),
                VEL_W'($urandom_range(1, 127)), $urandom_range(0, 250),
                CHAN_W'($urandom_range(1, 16)));
    if (pick < 55) begin
      w.opcode = OP_START;
      case ($urandom_range(0, 19))
        0: w.note_velocity = '0;
        1: w.note_velocity = '1;
        2: w.hold_ms       = $urandom;
        3: w.hold_ms       = '0;
        4: w.note_channel  = CHAN_W'($urandom_range(0, 31));
        default: ;
      endcase
    end else if (pick >= 94) begin
      w = word_of(opcode_t'($urandom_range(0, 1)), $urandom,
                  NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
                  $urandom, CHAN_W'($urandom_range(0, 31)));
    end
    return w;
  endfunction

  // Offer one word after an optional random gap; return at the edge that takes it.
  // Valid stays high afterwards so back-to-back words need no second assignment.
  task automatic send_word(input item_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // Write both registers back to back; valid stays up across the pair.
  task automatic write_registers(input logic own_chan, input logic [CHAN_W-1:0] chan);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PER_NOTE_CHANNEL;
    cfg_data  <= CHAN_W'(own_chan);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_DEFAULT_CHANNEL;
    cfg_data  <= chan;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every expected word, then let a start that found no
  // free voice finish its scan. Sample pending away from the active edge.
  task automatic drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    for (int k = 0; k < count; k++) send_word(random_word());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings (global channel 1).
    send_word(word_of(OP_CHECK, 5, 0, 0, 0, 1));                   // empty table
    send_word(word_of(OP_START, 0, 0, 127, 0, 16));                // voice 0, due at 0
    send_word(word_of(OP_START, 0, 127, 0, 0, 1));                 // zero velocity
    send_word(word_of(OP_START, 10, 60, 1, 100, 0));               // fill voices 1..7
    send_word(word_of(OP_START, 10, 61, 64, 100, 31));
    send_word(word_of(OP_START, 10, 62, 100, 100, 1));
    send_word(word_of(OP_START, 10, 63, 127, 100, 16));
    send_word(word_of(OP_START, 10, 64, 85, 100, 5));
    send_word(word_of(OP_START, 10, 65, 42, 100, 10));
    send_word(word_of(OP_START, 10, 66, 127, 100, 15));
    send_word(word_of(OP_START, 10, 67, 99, 100, 2));              // table full: dropped
    send_word(word_of(OP_CHECK, 10, 0, 0, 0, 1));                  // only voice 0 due
    send_word(word_of(OP_START, 32'hFFFF_FFF0, 1, 2, 32'h20, 3));  // expiry wraps to 0x10
    send_word(word_of(OP_CHECK, 32'h10, 0, 0, 0, 1));              // due exactly now
    send_word(word_of(OP_CHECK, 109, 0, 0, 0, 1));                 // nothing due yet
    send_word(word_of(OP_CHECK, 110, 0, 0, 0, 1));                 // seven note-offs
    send_word(word_of(OP_START, 1, 42, 100, 32'hFFFF_FFFF, 9));    // max hold, wraps to 0
    send_word(word_of(OP_START, 1, 43, 100, 1000, 12));
    drain();
    // Switch mode while two notes sound: their note-offs use the new setting.
    write_registers(1'b1, CHAN_W'(16));
    send_word(word_of(OP_CHECK, 32'hFFFF_FFFF, 0, 0, 0, 1));
    drain();

    // No idling.
    write_registers(1'b0, CHAN_W'(16));
    run_phase(PHASE_ITEMS);
    drain();

    // Sender mostly idle.
    write_registers(1'b1, CHAN_W'(1));
    send_idle_pct = 76;
    run_phase(PHASE_ITEMS);
    drain();

    // Receiver mostly stalling.
    write_registers(1'b0, CHAN_W'($urandom_range(1, 16)));
    send_idle_pct = 0;
    recv_stall_pct <= 76;
    run_phase(PHASE_ITEMS);
    drain();

    // Both sides idling.
    write_registers(1'b1, CHAN_W'($urandom_range(1, 16)));
    send_idle_pct = 31;
    recv_stall_pct <= 31;
    run_phase(PHASE_ITEMS);
    drain();

    // Back pressure: receiver holds off while the sender keeps offering.
    write_registers(1'b0, CHAN_W'(1));
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_kick <= ~hold_kick;
    run_phase(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: timed_note_voice_allocator_core.f
+incdir+rtl
rtl/tnva_pkg.sv
rtl/tnva_cell.sv
rtl/timed_note_voice_allocator_core.sv
test/tnva_message_checker.sv
test/tb_timed_note_voice_allocator_core.sv
